@@ hdl/encoder_count_frame_assembler_defines.svh @@
// Assertion macros used by the checker file.
`ifndef ENCODER_COUNT_FRAME_ASSEMBLER_DEFINES_SVH
`define ENCODER_COUNT_FRAME_ASSEMBLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ECFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ECFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ecfa_pkg.sv @@
`timescale 1ns / 1ps

package ecfa_pkg;

  localparam int FRAME_BYTES = 4;
  localparam int HELD_DEPTH  = FRAME_BYTES - 1;

  // Event codes
  localparam logic [1:0] FUNC_BYTE     = 2'd0;
  localparam logic [1:0] FUNC_RX_ERROR = 2'd1;
  localparam logic [1:0] FUNC_TICK     = 2'd2;
  localparam logic [1:0] FUNC_SET_ZERO = 2'd3;

  // Configuration register indexes
  localparam logic CFG_ENABLE     = 1'b0;
  localparam logic CFG_IDLE_LIMIT = 1'b1;

  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd20;
  localparam logic [15:0] TICK_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } ecfa_in_t;

  typedef struct packed {
    logic               frame_done;
    logic signed [31:0] count;
    logic signed [31:0] rel_count;
    logic               zero_accepted;
    logic               partial_dropped;
    logic [1:0]         fill_level;
    logic [31:0]        byte_total;
    logic [31:0]        frame_total;
    logic [31:0]        error_total;
    logic [31:0]        partial_total;
    logic               zero_is_set;
  } ecfa_out_t;

endpackage

@@ hdl/encoder_count_frame_assembler.sv @@
`timescale 1ns / 1ps
// The result of an accepted event is registered in the output register.
// Throughput: one event per cycle while the output is not stalled; the output register
// accepts a new transaction in the same cycle the previous result is taken.
// Reset (rst, synchronous): counters, fill level and zero reference clear,
// enable returns to 1 and idle_limit to 20; held frame bytes are not cleared.
module encoder_count_frame_assembler import ecfa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  ecfa_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ecfa_out_t   out_data
);

  // Configuration
  logic        enable;
  logic [15:0] idle_limit;

  // Frame and counter state
  logic [7:0]  held_bytes [HELD_DEPTH];
  logic [1:0]  fill_count,      fill_count_next;
  logic [15:0] idle_ticks,      idle_ticks_next;
  logic [31:0] bytes_seen,      bytes_seen_next;
  logic [31:0] frames_seen,     frames_seen_next;
  logic [31:0] errors_seen,     errors_seen_next;
  logic [31:0] partials_seen,   partials_seen_next;
  logic [31:0] latest_count,    latest_count_next;
  logic [31:0] zero_reference,  zero_reference_next;
  logic [31:0] latest_relative, latest_relative_next;
  logic        zero_flag,       zero_flag_next;

  logic        done, accepted, dropped;
  logic        in_fire, hold_byte;
  logic [31:0] raw_frame;
  ecfa_out_t   result;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Assembled frame, little endian, last byte on top
  assign raw_frame = {in_data.data_byte, held_bytes[2], held_bytes[1], held_bytes[0]};

  // Next state for one event
  always_comb begin
    fill_count_next      = fill_count;
    idle_ticks_next      = idle_ticks;
    bytes_seen_next      = bytes_seen;
    frames_seen_next     = frames_seen;
    errors_seen_next     = errors_seen;
    partials_seen_next   = partials_seen;
    latest_count_next    = latest_count;
    zero_reference_next  = zero_reference;
    latest_relative_next = latest_relative;
    zero_flag_next       = zero_flag;
    done                 = 1'b0;
    accepted             = 1'b0;
    dropped              = 1'b0;
    hold_byte            = 1'b0;
    if (enable) begin
      unique case (in_data.func)
        FUNC_BYTE: begin
          bytes_seen_next = bytes_seen + 32'd1;
          idle_ticks_next = '0;
          if (fill_count != 2'(HELD_DEPTH)) begin
            hold_byte       = 1'b1;
            fill_count_next = fill_count + 2'd1;
          end else begin
            latest_count_next    = raw_frame;
            latest_relative_next = zero_flag ? (raw_frame - zero_reference) : raw_frame;
            frames_seen_next     = frames_seen + 32'd1;
            fill_count_next      = '0;
            done                 = 1'b1;
          end
        end
        FUNC_RX_ERROR: begin
          errors_seen_next = errors_seen + 32'd1;
          fill_count_next  = '0;
        end
        FUNC_TICK: begin
          if (idle_ticks != TICK_MAX) idle_ticks_next = idle_ticks + 16'd1;
          if (fill_count != 2'd0 && idle_ticks_next >= idle_limit) begin
            fill_count_next    = '0;
            partials_seen_next = partials_seen + 32'd1;
            dropped            = 1'b1;
          end
        end
        FUNC_SET_ZERO: begin
          if (frames_seen != 32'd0) begin
            zero_reference_next  = latest_count;
            zero_flag_next       = 1'b1;
            latest_relative_next = '0;
            accepted             = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result built from the updated state
  always_comb begin
    result.frame_done      = done;
    result.count           = latest_count_next;
    result.rel_count       = latest_relative_next;
    result.zero_accepted   = accepted;
    result.partial_dropped = dropped;
    result.fill_level      = fill_count_next;
    result.byte_total      = bytes_seen_next;
    result.frame_total     = frames_seen_next;
    result.error_total     = errors_seen_next;
    result.partial_total   = partials_seen_next;
    result.zero_is_set     = zero_flag_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      idle_limit <= IDLE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ENABLE:     enable     <= cfg_wdata[0];
        CFG_IDLE_LIMIT: idle_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count      <= '0;
      idle_ticks      <= '0;
      bytes_seen      <= '0;
      frames_seen     <= '0;
      errors_seen     <= '0;
      partials_seen   <= '0;
      latest_count    <= '0;
      zero_reference  <= '0;
      latest_relative <= '0;
      zero_flag       <= 1'b0;
    end else if (in_fire) begin
      fill_count      <= fill_count_next;
      idle_ticks      <= idle_ticks_next;
      bytes_seen      <= bytes_seen_next;
      frames_seen     <= frames_seen_next;
      errors_seen     <= errors_seen_next;
      partials_seen   <= partials_seen_next;
      latest_count    <= latest_count_next;
      zero_reference  <= zero_reference_next;
      latest_relative <= latest_relative_next;
      zero_flag       <= zero_flag_next;
    end
  end

  // Partial frame bytes, no reset
  always_ff @(posedge clk) begin
    if (in_fire && hold_byte) begin
      held_bytes[fill_count] <= in_data.data_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result;
    end
  end

endmodule

@@ hdl/ecfa_checker.sv @@
`timescale 1ns / 1ps
`include "encoder_count_frame_assembler_defines.svh"

module ecfa_checker import ecfa_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input ecfa_out_t out_data
);

  logic       stall;
  logic [2:0] flags;
  logic       ends_frame;
  logic       zero_taken;
  logic       zero_ok;

  assign stall      = out_valid && !out_ready;
  assign flags      = {out_data.frame_done, out_data.zero_accepted, out_data.partial_dropped};
  assign ends_frame = out_valid && (out_data.frame_done || out_data.partial_dropped);
  assign zero_taken = out_valid && out_data.zero_accepted;
  assign zero_ok    = out_data.zero_is_set && (out_data.rel_count == 32'sd0);

  // A stalled result holds
  `ECFA_ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(out_data), "stalled result changed")

  // One event raises at most one flag
  `ECFA_ASSERT_NOW(a_flags_excl, out_valid, $onehot0(flags), "more than one event flag")

  // A completed or dropped frame leaves nothing held
  `ECFA_ASSERT_NOW(a_fill_clear, ends_frame, out_data.fill_level == 2'd0, "fill level not cleared")

  // Accepted zero sets the flag and clears the relative count
  `ECFA_ASSERT_NOW(a_zero_take, zero_taken, zero_ok, "zero capture inconsistent")

  // Zero is never accepted before a frame has been counted
  `ECFA_ASSERT_NOW(a_zero_frame, zero_taken, out_data.frame_total != 32'd0, "zero before frame")

endmodule

bind encoder_count_frame_assembler ecfa_checker u_ecfa_checker (.*);
